// File: sv/tla_pkg.sv
// Shared types, character codes and sizes for the text line annotator.
package tla_pkg;

    // Sizes
    localparam int P_NUMBER_DIGITS = 6;
    localparam int P_QUEUE_DEPTH   = 4;
    localparam int MAX_BURST       = 11;
    localparam int BURST_W         = 4;
    localparam int CNT_DIGITS_MAX  = 6;
    localparam int BCD_W           = CNT_DIGITS_MAX * 4;
    localparam int CFG_IDX_W       = 3;

    localparam logic [BCD_W-1:0] BCD_ONE = BCD_W'(1);

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_CTRL   = 8'h40;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_META   = 8'h80;
    localparam logic [7:0] CH_META_END = 8'hA0;

    // Configuration register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SQUEEZE_BLANK    = 3'd0,
        REG_NUMBER_NONBLANK  = 3'd1,
        REG_NUMBER_ALL       = 3'd2,
        REG_SHOW_ENDS        = 3'd3,
        REG_SHOW_TABS        = 3'd4,
        REG_SHOW_NONPRINTING = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic squeeze_blank;
        logic number_nonblank;
        logic number_all;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } t_cfg;

    // Prefix placed in front of the final character
    typedef enum logic [1:0] {
        PRE_NONE,
        PRE_CARET,
        PRE_META
    } t_prefix;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       starts_file;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_burst;
    } t_out_item;

    // One classified burst, as queued between front and back
    typedef struct packed {
        logic               num_en;
        logic [BCD_W-1:0]   digits;
        logic               dollar;
        t_prefix            prefix;
        logic [7:0]         ch;
        logic [BURST_W-1:0] len;
    } t_burst;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: sv/tla_front.sv
// Front end: configuration, line state and classification of each input byte.
module tla_front import tla_pkg::*; #(
    parameter int NUMBER_DIGITS = P_NUMBER_DIGITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    input  t_q_stat              i_q_stat,
    output logic                 o_push,
    output t_burst               o_push_data
);

    localparam int CNT_DIGITS = (NUMBER_DIGITS < CNT_DIGITS_MAX) ? NUMBER_DIGITS
                                                                  : CNT_DIGITS_MAX;
    localparam int TOT_W  = $clog2(NUMBER_DIGITS + 7);
    localparam int CALC_W = (TOT_W > BURST_W) ? TOT_W : BURST_W;

    t_cfg             r_cfg;
    logic [BCD_W-1:0] r_bcd;
    logic             r_at_start;
    logic [1:0]       r_hist_len;
    logic             r_prev_nl;
    logic             r_pprev_nl;

    logic [BCD_W-1:0] n_bcd;
    logic             n_at_start;
    logic [1:0]       n_hist_len;
    logic             n_prev_nl;
    logic             n_pprev_nl;

    logic [7:0]       c;
    logic             accept;
    logic             is_nl;
    logic             vis;
    logic             squeeze;
    logic             num_en;
    logic             tab_shown;
    logic             dollar;
    logic             sat;
    logic             carry;
    logic [3:0]       dig;
    logic [BCD_W-1:0] bcd_inc;
    logic [7:0]       out_ch;
    t_prefix          prefix;
    logic [CALC_W-1:0] tot;

    // Effective line state after a file start
    logic [BCD_W-1:0] e_bcd;
    logic             e_at_start;
    logic [1:0]       e_hist_len;
    logic             e_prev_nl;
    logic             e_pprev_nl;

    assign c          = i_in_data.data_byte;
    assign accept     = i_in_valid && !i_q_stat.full;
    assign o_in_stall = i_q_stat.full;

    // Classification and next line state
    always_comb begin
        e_bcd      = i_in_data.starts_file ? BCD_ONE : r_bcd;
        e_at_start = i_in_data.starts_file ? 1'b1 : r_at_start;
        e_hist_len = i_in_data.starts_file ? 2'd0 : r_hist_len;
        e_prev_nl  = i_in_data.starts_file ? 1'b0 : r_prev_nl;
        e_pprev_nl = i_in_data.starts_file ? 1'b0 : r_pprev_nl;

        is_nl = (c == CH_NL);
        vis   = r_cfg.show_nonprinting || r_cfg.show_ends || r_cfg.show_tabs;

        squeeze = r_cfg.squeeze_blank && is_nl && (e_hist_len != 2'd0) && e_prev_nl &&
                  ((e_hist_len == 2'd1) || e_pprev_nl);

        // numbering decision
        num_en     = 1'b0;
        n_at_start = e_at_start;
        if (r_cfg.number_nonblank) begin
            num_en = e_at_start && !is_nl;
        end else if (r_cfg.number_all) begin
            num_en = e_at_start;
        end
        if (r_cfg.number_nonblank || r_cfg.number_all) begin
            n_at_start = is_nl ? 1'b1 : (num_en ? 1'b0 : e_at_start);
        end

        // decimal counter, saturating when its digits are all nine
        sat     = 1'b1;
        carry   = 1'b1;
        bcd_inc = e_bcd;
        for (int j = 0; j < CNT_DIGITS_MAX; j++) begin
            if (j < CNT_DIGITS) begin
                dig = e_bcd[j*4 +: 4];
                sat = sat && (dig == 4'd9);
                if (carry) begin
                    bcd_inc[j*4 +: 4] = (dig == 4'd9) ? 4'd0 : dig + 4'd1;
                end
                carry = carry && (dig == 4'd9);
            end else begin
                dig = 4'd0;
            end
        end
        n_bcd = (num_en && !sat) ? bcd_inc : e_bcd;

        dollar    = r_cfg.show_ends && is_nl;
        tab_shown = r_cfg.show_tabs && (c == CH_TAB);

        // caret and meta notation
        prefix = PRE_NONE;
        out_ch = c;
        if (tab_shown) begin
            prefix = PRE_CARET;
            out_ch = CH_I;
        end else if (vis && !is_nl && (c != CH_TAB)) begin
            if (c < CH_SPACE) begin
                prefix = PRE_CARET;
                out_ch = c + CH_CTRL;
            end else if (c == CH_DEL) begin
                prefix = PRE_CARET;
                out_ch = CH_QMARK;
            end else if ((c > CH_META) && (c < CH_META_END)) begin
                prefix = PRE_META;
                out_ch = c - CH_CTRL;
            end
        end

        // history of emitted characters; a shown tab leaves it alone
        n_hist_len = e_hist_len;
        n_prev_nl  = e_prev_nl;
        n_pprev_nl = e_pprev_nl;
        if (!tab_shown) begin
            n_pprev_nl = e_prev_nl;
            n_prev_nl  = is_nl;
            n_hist_len = (e_hist_len == 2'd2) ? 2'd2 : e_hist_len + 2'd1;
        end

        // burst length, capped
        tot = CALC_W'(1) + CALC_W'(dollar);
        if (num_en) begin
            tot = tot + CALC_W'(NUMBER_DIGITS + 1);
        end
        case (prefix)
            PRE_CARET: tot = tot + CALC_W'(1);
            PRE_META:  tot = tot + CALC_W'(3);
            default:   tot = tot;
        endcase

        o_push_data.num_en = num_en;
        o_push_data.digits = e_bcd;
        o_push_data.dollar = dollar;
        o_push_data.prefix = prefix;
        o_push_data.ch     = out_ch;
        o_push_data.len    = (tot > CALC_W'(MAX_BURST)) ? BURST_W'(MAX_BURST)
                                                        : tot[BURST_W-1:0];
    end

    assign o_push = accept && !squeeze;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg_data;
                REG_NUMBER_NONBLANK:  r_cfg.number_nonblank  <= i_cfg_data;
                REG_NUMBER_ALL:       r_cfg.number_all       <= i_cfg_data;
                REG_SHOW_ENDS:        r_cfg.show_ends        <= i_cfg_data;
                REG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg_data;
                REG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_data;
                default:              r_cfg <= r_cfg;
            endcase
        end
    end

    // Line state; a squeezed newline changes nothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcd      <= BCD_ONE;
            r_at_start <= 1'b1;
            r_hist_len <= 2'd0;
            r_prev_nl  <= 1'b0;
            r_pprev_nl <= 1'b0;
        end else if (o_push) begin
            r_bcd      <= n_bcd;
            r_at_start <= n_at_start;
            r_hist_len <= n_hist_len;
            r_prev_nl  <= n_prev_nl;
            r_pprev_nl <= n_pprev_nl;
        end
    end

endmodule

// File: sv/tla_queue.sv
// Short burst queue between the front end and the back end.
module tla_queue import tla_pkg::*; #(
    parameter int DEPTH = P_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_burst  i_push_data,
    input  logic    i_pop,
    output t_burst  o_head,
    output t_q_stat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_burst          r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: sv/tla_back.sv
// Back end: walks the head burst, unless stalled, one character a cycle into the output register.
module tla_back import tla_pkg::*; #(
    parameter int NUMBER_DIGITS = P_NUMBER_DIGITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_burst    i_head,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int CNT_DIGITS = (NUMBER_DIGITS < CNT_DIGITS_MAX) ? NUMBER_DIGITS
                                                                  : CNT_DIGITS_MAX;
    localparam int TOT_W  = $clog2(NUMBER_DIGITS + 7);
    localparam int CALC_W = (TOT_W > BURST_W) ? TOT_W : BURST_W;
    localparam int DIG_AW = $clog2(CNT_DIGITS_MAX);

    logic [BURST_W-1:0] r_pos;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               load;
    logic               last;
    logic [CALC_W-1:0]  p;
    logic [CALC_W-1:0]  nlen;
    logic [CALC_W-1:0]  rem;
    logic [CALC_W-1:0]  j;
    logic               hz;
    logic [3:0]         dig;
    logic [7:0]         dch [CNT_DIGITS_MAX];
    logic [7:0]         ch;

    assign load  = !i_q_stat.empty && (!r_out_valid || !i_out_stall);
    assign last  = (r_pos == i_head.len - BURST_W'(1));
    assign o_pop = load && last;

    // Digit characters, leading zeros blanked but for the units digit
    always_comb begin
        hz = 1'b1;
        for (int k = CNT_DIGITS_MAX - 1; k >= 0; k--) begin
            dig = i_head.digits[k*4 +: 4];
            if (k < CNT_DIGITS) begin
                hz = hz && (dig == 4'd0);
                dch[k] = (hz && (k != 0)) ? CH_SPACE : CH_ZERO + {4'd0, dig};
            end else begin
                dch[k] = CH_SPACE;
            end
        end
    end

    // Character at the current position of the burst
    always_comb begin
        p    = CALC_W'(r_pos);
        nlen = i_head.num_en ? CALC_W'(NUMBER_DIGITS + 1) : '0;
        rem  = p - nlen - CALC_W'(i_head.dollar);
        j    = CALC_W'(NUMBER_DIGITS - 1) - p;
        ch   = i_head.ch;
        if (p < nlen) begin
            if (p < CALC_W'(NUMBER_DIGITS)) begin
                ch = (j < CALC_W'(CNT_DIGITS)) ? dch[j[DIG_AW-1:0]] : CH_SPACE;
            end else begin
                ch = CH_TAB;
            end
        end else if (i_head.dollar && (p == nlen)) begin
            ch = CH_DOLLAR;
        end else begin
            case (i_head.prefix)
                PRE_CARET: ch = (rem == '0) ? CH_CARET : i_head.ch;
                PRE_META: begin
                    if (rem == '0) begin
                        ch = CH_M;
                    end else if (rem == CALC_W'(1)) begin
                        ch = CH_DASH;
                    end else if (rem == CALC_W'(2)) begin
                        ch = CH_CARET;
                    end else begin
                        ch = i_head.ch;
                    end
                end
                default:   ch = i_head.ch;
            endcase
        end
    end

    // Output register and burst position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_pos       <= last ? '0 : r_pos + BURST_W'(1);
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_char      <= ch;
            r_out.last_of_burst <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: sv/text_line_annotator_core.sv
// Text line annotator: byte stream in, annotated character bursts out.
//
// Input channel: i_in_valid / o_in_stall carry one byte and a file-start flag.
// Output channel: o_out_valid / i_out_stall carry one character per
// transaction; last_of_burst marks the final character caused by a byte.
// A squeezed newline is accepted and gives no output at all.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
// the user must write it only while the block is idle; not enforced here.
// An accepted byte's burst is registered in the burst queue and its first
// character then in the back-end output register. Throughput: one byte per
// cycle while each burst is one character and the output is not stalled;
// longer bursts are paced by the one-character-a-cycle output register.
// A four-entry burst queue lets the front keep taking bytes while the
// back end drains a longer burst or the receiver stalls; the input stalls
// only when that queue is full.
// Synchronous reset clears the configuration, sets the line number to one,
// empties the history and the queue and drops any pending output.
module text_line_annotator_core import tla_pkg::*; #(
    parameter int NUMBER_DIGITS = P_NUMBER_DIGITS,
    parameter int QUEUE_DEPTH   = P_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data
);

    logic    q_push;
    t_burst  q_push_data;
    logic    q_pop;
    t_burst  q_head;
    t_q_stat q_stat;

    // Classification
    tla_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_stat    (q_stat),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    // Burst queue
    tla_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_stat      (q_stat)
    );

    // Serialisation
    tla_back #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_q_stat    (q_stat),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // Queue cannot be full and empty at once
    a_q_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("burst queue full and empty together");

    // Output only starts from a queued burst
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!q_stat.empty))
        else $error("output valid without a queued burst");

    // Retiring a burst leaves its final character in the output register
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (o_out_valid && o_out_data.last_of_burst))
        else $error("burst retired without its final character");

    // Reset drops pending output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule
